FILE: src/vllf_pkg.sv
// ----------------------------------------------------------------------------
// vllf_pkg: shared types and constants
// Sizes, config register codes and controller/datapath command and status
// bundles for the voxel label log-likelihood fusion block.
// ----------------------------------------------------------------------------
package vllf_pkg;

    localparam int VOXELS     = 4096;
    localparam int MAX_LABELS = 32;
    localparam int VOX_W      = $clog2(VOXELS);
    localparam int LAB_W      = 5;
    localparam int CNT_W      = 16;
    localparam int LCNT_W     = 6;
    localparam int LOG_W      = 21;
    localparam int PROB_W     = 32;
    localparam int PROD_W     = CNT_W + 1 + LOG_W;
    localparam int SUM_W      = PROD_W + 1;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = LOG_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_LABEL_COUNT   = 3'd0,
        CFG_LOG_MATCH     = 3'd1,
        CFG_LOG_NON_MATCH = 3'd2,
        CFG_LOG_INIT      = 3'd3,
        CFG_UNKNOWN_LABEL = 3'd4
    } t_cfg_idx;

    typedef struct packed {
        logic        [LCNT_W-1:0] label_count;
        logic signed [LOG_W-1:0]  log_match;
        logic signed [LOG_W-1:0]  log_non_match;
        logic signed [LOG_W-1:0]  log_init;
        logic        [LAB_W-1:0]  unknown_label;
    } t_cfg;

    typedef struct packed {
        logic             load;
        logic             mul_en;
        logic             mul_other;
        logic             rd_en;
        logic [LAB_W-1:0] rd_idx;
        logic             seen_wr;
        logic             out_load;
        logic             clr_en;
        logic [VOX_W-1:0] clr_addr;
    } t_cmd;

    typedef struct packed {
        logic bad;
    } t_sts;

    typedef struct packed {
        logic        [LAB_W-1:0]  best_label;
        logic signed [PROB_W-1:0] best_log_prob;
        logic                     bad_label;
    } t_result;

    // labels in use, clamped to 1..MAX_LABELS
    function automatic logic [LCNT_W-1:0] active_labels(input logic [LCNT_W-1:0] cnt);
        logic [LCNT_W-1:0] n;
        n = cnt;
        if (cnt == '0) begin
            n = LCNT_W'(1);
        end else if (cnt > LCNT_W'(MAX_LABELS)) begin
            n = LCNT_W'(MAX_LABELS);
        end
        return n;
    endfunction

endpackage

FILE: src/vllf_in_if.sv
// ----------------------------------------------------------------------------
// vllf_in_if: observation channel
// Valid/ready channel carrying one voxel observation per beat.
// ----------------------------------------------------------------------------
interface vllf_in_if;
    logic                            valid;
    logic                            ready;
    logic [vllf_pkg::VOX_W-1:0]      voxel_index;
    logic [vllf_pkg::LAB_W-1:0]      label;
    logic [vllf_pkg::CNT_W-1:0]      obs_count;

    modport source (output valid, output voxel_index, output label, output obs_count,
                    input ready);
    modport sink   (input valid, input voxel_index, input label, input obs_count,
                    output ready);
endinterface

FILE: src/vllf_out_if.sv
// ----------------------------------------------------------------------------
// vllf_out_if: result channel
// Valid/ready channel carrying the arg-max label of one voxel per beat.
// ----------------------------------------------------------------------------
interface vllf_out_if;
    logic                              valid;
    logic                              ready;
    logic        [vllf_pkg::LAB_W-1:0]  best_label;
    logic signed [vllf_pkg::PROB_W-1:0] best_log_prob;
    logic                              bad_label;

    modport source (output valid, output best_label, output best_log_prob,
                    output bad_label, input ready);
    modport sink   (input valid, input best_label, input best_log_prob,
                    input bad_label, output ready);
endinterface

FILE: src/voxel_label_log_likelihood_fusion.sv
// ----------------------------------------------------------------------------
// voxel_label_log_likelihood_fusion: per-voxel semantic label fusion
// Log-domain Bayesian label update over a voxel's label vector, with the
// arg-max label returned for every observation.
//
//   channel   dir  payload                                   beat
//   i_in      in   voxel_index, label, obs_count             one observation
//   o_out     out  best_label, best_log_prob, bad_label      one result
//   i_cfg_*   in   i_cfg_idx, i_cfg_data                     one register write
//
// An observation is loaded at its accepting edge; its result is then formed by
// two multiplies on the shared multiplier, a 32-entry scan of the label vector
// (one read and at most one write of one entry per cycle), the fold of the last
// entry and the hand-off. No new observation is taken before the last is handed off.
// After reset the seen map is cleared one voxel per cycle, during which no
// observation is taken; config writes are taken throughout.
// The next observation is taken while a result waits; it stalls at hand-off
// until the waiting result is taken.
// ----------------------------------------------------------------------------
module voxel_label_log_likelihood_fusion (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    vllf_in_if.sink                              i_in,
    vllf_out_if.source                           o_out,
    input  logic                                 i_cfg_we,
    input  logic [vllf_pkg::CFG_IDX_W-1:0]       i_cfg_idx,
    input  logic [vllf_pkg::CFG_DATA_W-1:0]      i_cfg_data
);

    vllf_pkg::t_cfg    r_cfg;
    vllf_pkg::t_cmd    w_cmd;
    vllf_pkg::t_sts    w_sts;
    vllf_pkg::t_result w_result;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.label_count   <= vllf_pkg::LCNT_W'(32);
            r_cfg.log_match     <= vllf_pkg::LOG_W'(-6905);
            r_cfg.log_non_match <= vllf_pkg::LOG_W'(-150902);
            r_cfg.log_init      <= vllf_pkg::LOG_W'(-227130);
            r_cfg.unknown_label <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                vllf_pkg::CFG_LABEL_COUNT:   r_cfg.label_count   <= i_cfg_data[vllf_pkg::LCNT_W-1:0];
                vllf_pkg::CFG_LOG_MATCH:     r_cfg.log_match     <= i_cfg_data;
                vllf_pkg::CFG_LOG_NON_MATCH: r_cfg.log_non_match <= i_cfg_data;
                vllf_pkg::CFG_LOG_INIT:      r_cfg.log_init      <= i_cfg_data;
                vllf_pkg::CFG_UNKNOWN_LABEL: r_cfg.unknown_label <= i_cfg_data[vllf_pkg::LAB_W-1:0];
                default: begin
                end
            endcase
        end
    end

    vllf_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    vllf_datapath u_datapath (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg         (r_cfg),
        .i_cmd         (w_cmd),
        .o_sts         (w_sts),
        .i_voxel_index (i_in.voxel_index),
        .i_label       (i_in.label),
        .i_obs_count   (i_in.obs_count),
        .o_result      (w_result)
    );

    assign o_out.best_label    = w_result.best_label;
    assign o_out.best_log_prob = w_result.best_log_prob;
    assign o_out.bad_label     = w_result.bad_label;

endmodule

FILE: src/vllf_ctrl.sv
// ----------------------------------------------------------------------------
// vllf_ctrl: sequencing controller
// Clears the seen map after reset, then steps each observation through
// lookup, two multiplies, a 32-entry scan and result hand-off.
// ----------------------------------------------------------------------------
module vllf_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    input  vllf_pkg::t_sts   i_sts,
    output vllf_pkg::t_cmd   o_cmd
);

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_MUL_A,
        S_MUL_B,
        S_SCAN,
        S_DRAIN,
        S_FINISH
    } t_state;

    localparam logic [vllf_pkg::LAB_W-1:0] LAST_IDX = vllf_pkg::LAB_W'(vllf_pkg::MAX_LABELS - 1);
    localparam logic [vllf_pkg::VOX_W-1:0] LAST_VOX = vllf_pkg::VOX_W'(vllf_pkg::VOXELS - 1);

    t_state                     r_state, n_state;
    logic [vllf_pkg::LAB_W-1:0] r_idx, n_idx;
    logic [vllf_pkg::VOX_W-1:0] r_clr_addr, n_clr_addr;
    logic                       r_out_valid, n_out_valid;
    vllf_pkg::t_cmd             w_cmd;

    always_comb begin
        n_state     = r_state;
        n_idx       = r_idx;
        n_clr_addr  = r_clr_addr;
        n_out_valid = r_out_valid;
        w_cmd       = '0;
        if (r_out_valid && i_out_ready) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_CLEAR: begin
                w_cmd.clr_en   = 1'b1;
                w_cmd.clr_addr = r_clr_addr;
                n_clr_addr     = r_clr_addr + 1'b1;
                if (r_clr_addr == LAST_VOX) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_MUL_A;
                end
            end
            S_MUL_A: begin
                w_cmd.mul_en = 1'b1;
                n_state      = S_MUL_B;
            end
            S_MUL_B: begin
                w_cmd.mul_en    = 1'b1;
                w_cmd.mul_other = 1'b1;
                n_idx           = '0;
                n_state         = S_SCAN;
            end
            S_SCAN: begin
                w_cmd.rd_en  = 1'b1;
                w_cmd.rd_idx = r_idx;
                n_idx        = r_idx + 1'b1;
                if (r_idx == LAST_IDX) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                // last read entry is folded in this cycle
                n_state = S_FINISH;
            end
            S_FINISH: begin
                if (!r_out_valid || i_out_ready) begin
                    w_cmd.out_load = 1'b1;
                    w_cmd.seen_wr  = !i_sts.bad;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_CLEAR;
            r_idx       <= '0;
            r_clr_addr  <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_idx       <= n_idx;
            r_clr_addr  <= n_clr_addr;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_cmd       = w_cmd;

`ifndef SYNTH
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result overwritten before it was taken");

    a_out_drop: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_ready && !w_cmd.out_load) |=> !r_out_valid)
        else $error("result beat repeated");

    a_scan_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_SCAN && r_idx != LAST_IDX) |=>
            (r_state == S_SCAN && r_idx == vllf_pkg::LAB_W'($past(r_idx) + 1'b1)))
        else $error("scan skipped an entry");

    a_clear_blocks: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_cmd.clr_en |-> (!w_cmd.load && !w_cmd.seen_wr))
        else $error("item taken during seen-map clear");
`endif

endmodule

FILE: src/vllf_datapath.sv
// ----------------------------------------------------------------------------
// vllf_datapath: label vector storage and update datapath
// Holds the seen map and per-voxel log-probability vectors, forms the two
// count*log products and runs the read-modify-write scan with arg-max.
// ----------------------------------------------------------------------------
module vllf_datapath (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  vllf_pkg::t_cfg                  i_cfg,
    input  vllf_pkg::t_cmd                  i_cmd,
    output vllf_pkg::t_sts                  o_sts,
    input  logic [vllf_pkg::VOX_W-1:0]      i_voxel_index,
    input  logic [vllf_pkg::LAB_W-1:0]      i_label,
    input  logic [vllf_pkg::CNT_W-1:0]      i_obs_count,
    output vllf_pkg::t_result               o_result
);

    localparam int ADDR_W = vllf_pkg::VOX_W + vllf_pkg::LAB_W;
    localparam logic signed [vllf_pkg::SUM_W-1:0] SAT_MAX =
        vllf_pkg::SUM_W'(64'sh7FFF_FFFF);
    localparam logic signed [vllf_pkg::SUM_W-1:0] SAT_MIN =
        -vllf_pkg::SUM_W'(64'sh8000_0000);

    logic                                mem_seen [vllf_pkg::VOXELS];
    logic signed [vllf_pkg::PROB_W-1:0]  mem_lp   [vllf_pkg::VOXELS * vllf_pkg::MAX_LABELS];

    logic        [vllf_pkg::VOX_W-1:0]   r_vox;
    logic        [vllf_pkg::LAB_W-1:0]   r_lab;
    logic        [vllf_pkg::CNT_W-1:0]   r_cnt;
    logic                                r_seen;
    logic                                r_bad;
    logic                                r_upd;
    logic signed [vllf_pkg::PROD_W-1:0]  r_add_match;
    logic signed [vllf_pkg::PROD_W-1:0]  r_add_other;
    logic signed [vllf_pkg::PROB_W-1:0]  r_rd_data;
    logic                                r_p_valid;
    logic        [vllf_pkg::LAB_W-1:0]   r_p_idx;
    logic        [vllf_pkg::LAB_W-1:0]   r_best_idx;
    logic signed [vllf_pkg::PROB_W-1:0]  r_best_val;
    vllf_pkg::t_result                   r_result;

    logic        [vllf_pkg::LCNT_W-1:0]  w_n;
    logic signed [vllf_pkg::LOG_W-1:0]   w_mul_b;
    logic signed [vllf_pkg::PROD_W-1:0]  w_prod;
    logic signed [vllf_pkg::PROB_W-1:0]  w_init;
    logic signed [vllf_pkg::PROB_W-1:0]  w_cur;
    logic signed [vllf_pkg::PROD_W-1:0]  w_add;
    logic signed [vllf_pkg::SUM_W-1:0]   w_sum;
    logic signed [vllf_pkg::PROB_W-1:0]  w_sat;
    logic signed [vllf_pkg::PROB_W-1:0]  w_new;
    logic                                w_active;
    logic                                w_lp_we;
    logic                                w_take;

    assign w_n    = vllf_pkg::active_labels(i_cfg.label_count);
    assign w_init = vllf_pkg::PROB_W'(i_cfg.log_init);

    // one multiplier, used for the matching and then the non-matching term
    assign w_mul_b = i_cmd.mul_other ? i_cfg.log_non_match : i_cfg.log_match;
    assign w_prod  = vllf_pkg::PROD_W'($signed({1'b0, r_cnt}))
                   * vllf_pkg::PROD_W'(w_mul_b);

    // entry stage: data read last cycle for index r_p_idx
    assign w_active = ({1'b0, r_p_idx} < w_n);
    assign w_cur    = r_seen ? r_rd_data : w_init;
    assign w_add    = (r_p_idx == r_lab) ? r_add_match : r_add_other;
    assign w_sum    = vllf_pkg::SUM_W'(w_cur) + vllf_pkg::SUM_W'(w_add);

    always_comb begin
        if (w_sum > SAT_MAX) begin
            w_sat = vllf_pkg::PROB_W'(SAT_MAX);
        end else if (w_sum < SAT_MIN) begin
            w_sat = vllf_pkg::PROB_W'(SAT_MIN);
        end else begin
            w_sat = vllf_pkg::PROB_W'(w_sum);
        end
    end

    assign w_new   = (!r_bad && r_upd && w_active) ? w_sat : w_cur;
    // first touch writes every entry, active or not
    assign w_lp_we = r_p_valid && !r_bad && (!r_seen || (r_upd && w_active));
    assign w_take  = r_p_valid && w_active && ((r_p_idx == '0) || (w_new > r_best_val));

    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_en) begin
            mem_seen[i_cmd.clr_addr] <= 1'b0;
        end else if (i_cmd.seen_wr) begin
            mem_seen[r_vox] <= 1'b1;
        end
        if (i_cmd.load) begin
            r_seen <= mem_seen[i_voxel_index];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_lp_we) begin
            mem_lp[{r_vox, r_p_idx}] <= w_new;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= mem_lp[ADDR_W'({r_vox, i_cmd.rd_idx})];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_p_valid <= 1'b0;
        end else begin
            r_p_valid <= i_cmd.rd_en;
        end
        r_p_idx <= i_cmd.rd_idx;
        if (i_cmd.load) begin
            r_vox <= i_voxel_index;
            r_lab <= i_label;
            r_cnt <= i_obs_count;
            r_bad <= ({1'b0, i_label} >= w_n);
            r_upd <= (i_label != i_cfg.unknown_label);
        end
        if (i_cmd.mul_en) begin
            if (i_cmd.mul_other) begin
                r_add_other <= w_prod;
            end else begin
                r_add_match <= w_prod;
            end
        end
        if (w_take) begin
            r_best_idx <= r_p_idx;
            r_best_val <= w_new;
        end
        if (i_cmd.out_load) begin
            r_result.best_label    <= r_best_idx;
            r_result.best_log_prob <= r_best_val;
            r_result.bad_label     <= r_bad;
        end
    end

    assign o_sts.bad = r_bad;
    assign o_result  = r_result;

endmodule

FILE: test/tb_top.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top: voxel label log-likelihood fusion testbench
// Drives observations through the valid/ready channel, folds each accepted
// beat into a local copy of every voxel's label vector and checks the
// returned arg-max label, its log probability and the bad-label flag.
// Directed cases cover field extremes, ties, unknown and out-of-range labels
// and saturation at both ends; random phases then sweep the config registers.
// ----------------------------------------------------------------------------
module tb_top;
    import vllf_pkg::*;

    localparam int CYCLE_LIMIT = 1000000;
    localparam int HOT_N       = 32;
    localparam int DRAIN_WAIT  = 48;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic                  cfg_we   = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx  = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    vllf_in_if  obs_if();
    vllf_out_if res_if();

    voxel_label_log_likelihood_fusion dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in       (obs_if),
        .o_out      (res_if),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // local copy of the config and of every voxel's label vector
    logic        [LCNT_W-1:0] lab_count_reg = LCNT_W'(32);
    logic signed [LOG_W-1:0]  hit_log_reg   = -21'sd6905;
    logic signed [LOG_W-1:0]  miss_log_reg  = -21'sd150902;
    logic signed [LOG_W-1:0]  prior_log_reg = -21'sd227130;
    logic        [LAB_W-1:0]  unk_lab_reg   = '0;

    bit                       voxel_touched [VOXELS];
    logic signed [PROB_W-1:0] label_logp [VOXELS][MAX_LABELS];

    t_result pending_argmax[$];
    int      mismatch_cnt = 0;
    int      cycle_cnt    = 0;
    bit      src_idle     = 1'b1;
    bit      snk_idle     = 1'b1;
    logic [VOX_W-1:0] hot_vox [HOT_N];

    function automatic int labels_in_use();
        if (lab_count_reg == '0) return 1;
        if (lab_count_reg > LCNT_W'(MAX_LABELS)) return MAX_LABELS;
        return int'(lab_count_reg);
    endfunction

    function automatic logic signed [PROB_W-1:0] clamp_q16(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[PROB_W-1:0];
    endfunction

    // apply one observation to the local vectors and return the arg-max
    function automatic t_result fuse_observation(input logic [VOX_W-1:0] vox,
                                                 input logic [LAB_W-1:0] lab,
                                                 input logic [CNT_W-1:0] cnt);
        t_result                  r;
        int                       n;
        logic signed [PROB_W-1:0] prior;
        logic signed [PROB_W-1:0] v;
        longint                   add_hit;
        longint                   add_miss;
        n     = labels_in_use();
        prior = prior_log_reg;
        r.bad_label     = (int'(lab) >= n);
        r.best_label    = '0;
        r.best_log_prob = '0;
        if (!r.bad_label) begin
            if (!voxel_touched[vox]) begin
                for (int i = 0; i < MAX_LABELS; i++) label_logp[vox][i] = prior;
                voxel_touched[vox] = 1'b1;
            end
            if (lab != unk_lab_reg) begin
                add_hit  = longint'(cnt) * longint'(hit_log_reg);
                add_miss = longint'(cnt) * longint'(miss_log_reg);
                for (int i = 0; i < n; i++) begin
                    label_logp[vox][i] = clamp_q16(longint'(label_logp[vox][i]) +
                                                   ((i == int'(lab)) ? add_hit : add_miss));
                end
            end
        end
        for (int i = 0; i < n; i++) begin
            v = voxel_touched[vox] ? label_logp[vox][i] : prior;
            if (i == 0 || v > r.best_log_prob) begin
                r.best_label    = LAB_W'(i);
                r.best_log_prob = v;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatch_cnt < 40) $display("[%0d] mismatch: %s", cycle_cnt, msg);
        mismatch_cnt++;
    endtask

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(12, 64);
    endfunction

    function automatic logic [VOX_W-1:0] pick_voxel();
        if ($urandom_range(0, 99) < 75) return hot_vox[$urandom_range(0, HOT_N - 1)];
        return VOX_W'($urandom);
    endfunction

    function automatic logic [LAB_W-1:0] pick_label();
        int r;
        r = $urandom_range(0, 99);
        if (r < 12) return unk_lab_reg;
        if (r < 30) return LAB_W'($urandom);
        return LAB_W'($urandom_range(0, labels_in_use() - 1));
    endfunction

    function automatic logic [CNT_W-1:0] pick_count();
        int r;
        r = $urandom_range(0, 99);
        if (r < 55) return CNT_W'($urandom_range(0, 7));
        if (r < 80) return CNT_W'($urandom_range(0, 255));
        if (r < 94) return CNT_W'($urandom);
        return (r < 97) ? 16'hFFFF : 16'h0000;
    endfunction

    task automatic refresh_hot(input int k);
        repeat (k) hot_vox[$urandom_range(0, HOT_N - 1)] = VOX_W'($urandom);
    endtask

    // one observation beat; valid stays high on return so a back-to-back beat
    // can follow without a low cycle
    task automatic send_obs(input logic [VOX_W-1:0] vox, input logic [LAB_W-1:0] lab,
                            input logic [CNT_W-1:0] cnt);
        int gap;
        gap = src_idle ? pick_gap() : 0;
        if (gap > 0) begin
            obs_if.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        obs_if.valid       <= 1'b1;
        obs_if.voxel_index <= vox;
        obs_if.label       <= lab;
        obs_if.obs_count   <= cnt;
        do @(posedge i_clk); while (!obs_if.ready);
        pending_argmax.push_back(fuse_observation(vox, lab, cnt));
    endtask

    task automatic quiesce();
        obs_if.valid <= 1'b0;
        while (pending_argmax.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CFG_DATA_W-1:0] data);
        @(posedge i_clk);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        case (idx)
            CFG_LABEL_COUNT:   lab_count_reg = data[LCNT_W-1:0];
            CFG_LOG_MATCH:     hit_log_reg   = data;
            CFG_LOG_NON_MATCH: miss_log_reg  = data;
            CFG_LOG_INIT:      prior_log_reg = data;
            CFG_UNKNOWN_LABEL: unk_lab_reg   = data[LAB_W-1:0];
            default: ;
        endcase
    endtask

    task automatic load_config(input int lc, input int hit, input int miss,
                               input int prior, input int unk);
        quiesce();
        write_reg(CFG_LABEL_COUNT,   CFG_DATA_W'(lc));
        write_reg(CFG_LOG_MATCH,     CFG_DATA_W'(hit));
        write_reg(CFG_LOG_NON_MATCH, CFG_DATA_W'(miss));
        write_reg(CFG_LOG_INIT,      CFG_DATA_W'(prior));
        write_reg(CFG_UNKNOWN_LABEL, CFG_DATA_W'(unk));
        @(posedge i_clk);
        cfg_we <= 1'b0;
    endtask

    task automatic run_random(input int count);
        repeat (count) send_obs(pick_voxel(), pick_label(), pick_count());
    endtask

    // reset config: first touch, ties, all-ones/all-zeros and alternating fields
    task automatic test_reset_defaults();
        send_obs(12'd0,    5'd0,  16'd5);
        send_obs(12'd4095, 5'd31, 16'hFFFF);
        send_obs(12'd4095, 5'd31, 16'hFFFF);
        send_obs(12'd1,    5'd5,  16'd0);
        send_obs(12'd2,    5'd3,  16'd1);
        send_obs(12'd2,    5'd7,  16'd1);
        send_obs(12'hAAA,  5'h15, 16'hAAAA);
        send_obs(12'h555,  5'h0A, 16'h5555);
    endtask

    task automatic test_bad_and_unknown();
        load_config(4, -6905, -150902, -227130, 2);
        send_obs(12'd3, 5'd4,  16'd9);    // bad label, voxel never touched
        send_obs(12'd2, 5'd31, 16'd1);    // bad label on a touched voxel
        send_obs(12'd3, 5'd2,  16'd100);  // unknown label still initializes
        send_obs(12'd3, 5'd1,  16'd3);
        load_config(4, -6905, -150902, -227130, 9);
        send_obs(12'd5, 5'd9,  16'd1);    // unknown id beyond label count is bad
        send_obs(12'd5, 5'd3,  16'd1);
    endtask

    task automatic test_saturation();
        load_config(32, 1048575, -1048576, 1048575, 31);
        send_obs(12'd7, 5'd0,  16'hFFFF); // own entry clamps high, others low
        send_obs(12'd7, 5'd0,  16'hFFFF);
        send_obs(12'd8, 5'd31, 16'hFFFF);
        load_config(0, -1048576, -1048576, -1048576, 1);
        send_obs(12'd9, 5'd0,  16'hFFFF); // label count zero acts as one
        send_obs(12'd9, 5'd1,  16'd1);
    endtask

    task automatic test_config_sweep();
        for (int ph = 0; ph < 10; ph++) begin
            src_idle = (ph % 3 != 2);
            snk_idle = (ph % 3 != 2);
            refresh_hot(8);
            case (ph)
                0: load_config(32, -6905, -150902, -227130, 0);
                1: load_config(2, -1048576, 0, 0, 1);
                2: load_config(1, -1000, -2000, -3000, 0);
                3: load_config(63, -1, -1048576, -1048576, 31);
                4: load_config(17, 0, -70000, -50000, 16);
                5: load_config(33, -$urandom_range(0, 1048576), -$urandom_range(0, 1048576),
                               -$urandom_range(0, 1048576), $urandom_range(0, 31));
                6: load_config(5, 1048575, 1048575, 1048575, 3);
                7: load_config(24, -$urandom_range(0, 40000), -$urandom_range(0, 400000),
                               -$urandom_range(0, 1048576), 30);
                8: load_config($urandom_range(2, 32), $urandom, $urandom, $urandom, $urandom);
                default: load_config($urandom_range(0, 63), $urandom, $urandom, $urandom,
                                     $urandom);
            endcase
            run_random(105);
        end
    endtask

    task automatic test_default_stream();
        src_idle = 1'b0;
        snk_idle = 1'b0;
        load_config(32, -6905, -150902, -227130, 0);
        run_random(80);
    endtask

    // result sink back-pressure
    initial begin
        int stall_left;
        stall_left = 0;
        res_if.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= (stall_left == 0);
            end else if (snk_idle && $urandom_range(0, 4) == 0) begin
                res_if.ready <= 1'b0;
                stall_left = pick_gap() + 1;
            end else begin
                res_if.ready <= 1'b1;
            end
        end
    end

    always @(posedge i_clk) begin
        t_result want;
        if (i_rst_n && res_if.valid && res_if.ready) begin
            if (pending_argmax.size() == 0) begin
                report_mismatch($sformatf("unexpected result beat, label %0d value %0d",
                                          res_if.best_label, res_if.best_log_prob));
            end else begin
                want = pending_argmax.pop_front();
                if (res_if.best_label !== want.best_label)
                    report_mismatch($sformatf("best_label %0d, want %0d",
                                              res_if.best_label, want.best_label));
                if (res_if.best_log_prob !== want.best_log_prob)
                    report_mismatch($sformatf("best_log_prob %0d, want %0d",
                                              res_if.best_log_prob, want.best_log_prob));
                if (res_if.bad_label !== want.bad_label)
                    report_mismatch($sformatf("bad_label %0b, want %0b",
                                              res_if.bad_label, want.bad_label));
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt == CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    initial begin
        obs_if.valid       <= 1'b0;
        obs_if.voxel_index <= '0;
        obs_if.label       <= '0;
        obs_if.obs_count   <= '0;
        for (int i = 0; i < HOT_N; i++) hot_vox[i] = VOX_W'($urandom);
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        test_reset_defaults();
        test_bad_and_unknown();
        test_saturation();
        test_config_sweep();
        test_default_stream();

        quiesce();
        repeat (DRAIN_WAIT) @(posedge i_clk);
        if (pending_argmax.size() == 0 && mismatch_cnt == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
